### design/abs_pkg.sv
// Shared types and constants of the antialiased box splat.
// Used by the front end, the axis span unit, the job queue, the pixel back end and the top level.
package abs_pkg;

  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned MAX_BOX   = 8;

  // Largest effective side in Q.8 pixels.
  localparam logic [12:0] SIDE_MAX   = 13'((MAX_BOX - 1) << FRAC_BITS);
  localparam logic [12:0] CANVAS_MAX = 13'd4096;
  localparam logic [8:0]  ONE_PX     = 9'd256;

  // Division by 255 as a multiplication: q = (m * RECIP_255) >> RECIP_SHIFT, then one correction.
  localparam logic [16:0] RECIP_255   = 17'd32897;
  localparam int unsigned RECIP_SHIFT = 23;
  localparam logic [19:0] ALPHA_ROUND = 20'd127;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_CANVAS_WIDTH  = 2'd0;
  localparam logic [1:0] REG_CANVAS_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BOX_SIDE      = 2'd2;
  localparam logic [1:0] REG_SIDE_BY_ALPHA = 2'd3;

  typedef struct packed {
    logic [12:0] canvas_width;
    logic [12:0] canvas_height;
    logic [10:0] box_side;
    logic        side_by_alpha;
  } abs_cfg_t;

  // One axis of a box: first pixel, pixel count and the first and last weights.
  typedef struct packed {
    logic [11:0] start;
    logic [3:0]  count;
    logic [8:0]  w_first;
    logic [8:0]  w_last;
  } abs_span_t;

  // One classified particle waiting for the back end.
  typedef struct packed {
    abs_span_t  xs;
    abs_span_t  ys;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } abs_job_t;

endpackage

### design/abs_axis.sv
// Span unit for one axis: edges, clipping and weights of a box along x or y.
// Depends on abs_pkg for the span type.
module abs_axis
  import abs_pkg::*;
(
  input  logic        clk_i,
  input  logic        load_i,
  input  logic [21:0] center_i,
  input  logic [10:0] half_lo_i,
  input  logic [10:0] half_hi_i,
  input  logic [12:0] limit_i,
  output abs_span_t   span_o
);

  logic signed [22:0] lo, hi, lo_r, hi_r;
  logic signed [14:0] ceil_lo, ceil_hi, a2;
  logic [8:0]  e1, e2;
  logic [11:0] side_sum;
  logic        single, vis;

  logic signed [14:0] a1_q, a2_q;
  logic [8:0]  e1_q, e2_q, ws_q;
  logic        single_q, vis_q;

  // Box edges and their pixel ceilings.
  always_comb begin
    lo      = $signed({center_i[21], center_i}) - $signed({12'd0, half_lo_i});
    hi      = $signed({center_i[21], center_i}) + $signed({12'd0, half_hi_i});
    lo_r    = lo + 23'sd255;
    hi_r    = hi + 23'sd255;
    ceil_lo = lo_r[22:8];
    ceil_hi = hi_r[22:8];
    a2      = ceil_hi - 15'sd1;
    e1      = (lo[7:0] == 8'd0) ? 9'd0 : (ONE_PX - {1'b0, lo[7:0]});
    e2      = (hi[7:0] == 8'd0) ? ONE_PX : {1'b0, hi[7:0]};
    single  = (ceil_hi == ceil_lo);
    side_sum = {1'b0, half_lo_i} + {1'b0, half_hi_i};
    vis     = (ceil_lo <= $signed({2'b00, limit_i})) && !a2[14];
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      a1_q     <= ceil_lo;
      a2_q     <= a2;
      e1_q     <= e1;
      e2_q     <= e2;
      ws_q     <= side_sum[8:0];
      single_q <= single;
      vis_q    <= vis;
    end
  end

  logic signed [14:0] lim_s;
  logic        lead, trail;
  logic [12:0] a1c, a2c, mid, a1m;

  // Clip to the canvas and count the pixels of the span.
  always_comb begin
    lim_s = $signed({2'b00, limit_i});
    lead  = (a1_q > 15'sd0) && (e1_q != 9'd0);
    a1c   = (a1_q > 15'sd0) ? a1_q[12:0] : 13'd0;
    trail = (a2_q < lim_s);
    a2c   = trail ? a2_q[12:0] : limit_i;
    mid   = a2c - a1c;
    a1m   = a1c - 13'd1;
    if (!vis_q) begin
      span_o = '0;
    end else if (single_q) begin
      span_o.start   = a2_q[11:0];
      span_o.count   = 4'd1;
      span_o.w_first = ws_q;
      span_o.w_last  = ws_q;
    end else begin
      span_o.start   = lead ? a1m[11:0] : a1c[11:0];
      span_o.count   = mid[3:0] + {3'd0, lead} + {3'd0, trail};
      span_o.w_first = lead ? e1_q : ((mid != 13'd0) ? ONE_PX : e2_q);
      span_o.w_last  = trail ? e2_q : ((mid != 13'd0) ? ONE_PX : e1_q);
    end
  end

endmodule

### design/abs_front.sv
// Front end: accepts particles, sizes the box and classifies both axes into a job.
// Depends on abs_pkg and abs_axis.
module abs_front
  import abs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  abs_cfg_t    cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [21:0] center_x_i,
  input  logic [21:0] center_y_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic [7:0]  alpha_i,
  output logic        push_o,
  input  logic        full_i,
  output abs_job_t    job_o
);

  typedef enum logic [2:0] {ST_IDLE, ST_RECIP, ST_FIX, ST_AXIS, ST_PACK} state_e;
  state_e state_q;

  logic [21:0] cx_q, cy_q;
  logic [7:0]  red_q, green_q, blue_q, alpha_q;
  logic [18:0] prod_q;
  logic [19:0] m_q;
  logic [35:0] recip_q;
  logic [10:0] hl_q, hr_q;

  logic [19:0] m_d;
  logic [12:0] q0, q, side_sel, side_c;
  logic [20:0] q0_x255;
  logic [12:0] width_c, height_c;
  abs_span_t   xs, ys;
  logic        accept, empty;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Side: box_side, or round(side * alpha / 255) in alpha mode; then saturated.
  always_comb begin
    m_d      = {1'b0, prod_q} + ALPHA_ROUND;
    q0       = recip_q[35:RECIP_SHIFT];
    q0_x255  = {q0, 8'd0} - {8'd0, q0};
    q        = (q0_x255 > {1'b0, m_q}) ? (q0 - 13'd1) : q0;
    side_sel = cfg_i.side_by_alpha ? q : {2'b00, cfg_i.box_side};
    side_c   = (side_sel > SIDE_MAX) ? SIDE_MAX : side_sel;
    width_c  = (cfg_i.canvas_width > CANVAS_MAX) ? CANVAS_MAX : cfg_i.canvas_width;
    height_c = (cfg_i.canvas_height > CANVAS_MAX) ? CANVAS_MAX : cfg_i.canvas_height;
  end

  abs_axis u_axis_x (
    .clk_i     (clk_i),
    .load_i    (state_q == ST_AXIS),
    .center_i  (cx_q),
    .half_lo_i (hl_q),
    .half_hi_i (hr_q),
    .limit_i   (width_c),
    .span_o    (xs)
  );

  abs_axis u_axis_y (
    .clk_i     (clk_i),
    .load_i    (state_q == ST_AXIS),
    .center_i  (cy_q),
    .half_lo_i (hl_q),
    .half_hi_i (hr_q),
    .limit_i   (height_c),
    .span_o    (ys)
  );

  // A box with no pixel on one of its axes leaves nothing to do.
  assign empty  = (xs.count == 4'd0) || (ys.count == 4'd0);
  assign push_o = (state_q == ST_PACK) && !empty && !full_i;

  always_comb begin
    job_o.xs    = xs;
    job_o.ys    = ys;
    job_o.red   = red_q;
    job_o.green = green_q;
    job_o.blue  = blue_q;
    job_o.alpha = alpha_q;
  end

  // Sequencer with the payload registers of each step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_RECIP;
          end
        end
        ST_RECIP: state_q <= ST_FIX;
        ST_FIX:   state_q <= ST_AXIS;
        ST_AXIS:  state_q <= ST_PACK;
        ST_PACK: begin
          if (empty || !full_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cx_q    <= center_x_i;
      cy_q    <= center_y_i;
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
      alpha_q <= cfg_i.side_by_alpha ? 8'd255 : alpha_i;
      prod_q  <= {8'd0, cfg_i.box_side} * {11'd0, alpha_i};
    end
    if (state_q == ST_RECIP) begin
      m_q     <= m_d;
      recip_q <= {16'd0, m_d} * {19'd0, RECIP_255};
    end
    if (state_q == ST_FIX) begin
      hl_q <= side_c[11:1];
      hr_q <= side_c[10:0] - side_c[11:1];
    end
  end

endmodule

### design/abs_fifo.sv
// Short job queue between the front end and the back end.
// Depends on abs_pkg for the job type.
module abs_fifo
  import abs_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  abs_job_t wdata_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output abs_job_t rdata_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  abs_job_t mem_q [DEPTH];
  logic [AW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == FULL_CNT);
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == LAST_PTR) ? '0 : (wptr_q + AW'(1));
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == LAST_PTR) ? '0 : (rptr_q + AW'(1));
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

### design/abs_back.sv
// Back end: walks a job in row-major order and emits one weighted pixel a cycle while the output is not stalled.
// Depends on abs_pkg for the job type.
module abs_back
  import abs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  input  abs_job_t    job_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] pixel_x_o,
  output logic [11:0] pixel_y_o,
  output logic [8:0]  coverage_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  alpha_o,
  output logic        last_o
);

  abs_job_t   job_q;
  logic       busy_q, ov_q;
  logic [2:0] ix_q, iy_q;

  logic [11:0] px_q, py_q;
  logic [8:0]  cov_q;
  logic        last_q;
  logic [7:0]  red_q, green_q, blue_q, alpha_q;

  logic        emit, last_x, last_y;
  logic [3:0]  xm1, ym1;
  logic [8:0]  wx, wy;
  logic [17:0] prod;
  logic [17:0] prod_r;
  logic [9:0]  cov_raw;
  logic [8:0]  cov;

  assign pop_o = !busy_q && job_valid_i;
  assign emit  = busy_q && (!ov_q || out_ready_i);

  // Weight of the current column and row, and their product.
  always_comb begin
    xm1     = job_q.xs.count - 4'd1;
    ym1     = job_q.ys.count - 4'd1;
    last_x  = ({1'b0, ix_q} == xm1);
    last_y  = ({1'b0, iy_q} == ym1);
    wx      = (ix_q == 3'd0) ? job_q.xs.w_first : (last_x ? job_q.xs.w_last : ONE_PX);
    wy      = (iy_q == 3'd0) ? job_q.ys.w_first : (last_y ? job_q.ys.w_last : ONE_PX);
    prod    = {9'd0, wx} * {9'd0, wy};
    prod_r  = prod + 18'd128;
    cov_raw = prod_r[17:8];
    cov     = (cov_raw > 10'd256) ? ONE_PX : cov_raw[8:0];
  end

  // Walk control and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ov_q   <= 1'b0;
      ix_q   <= '0;
      iy_q   <= '0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        ix_q   <= '0;
        iy_q   <= '0;
      end else if (emit) begin
        if (last_x) begin
          ix_q <= '0;
          iy_q <= iy_q + 3'd1;
          if (last_y) begin
            busy_q <= 1'b0;
          end
        end else begin
          ix_q <= ix_q + 3'd1;
        end
      end
      if (emit) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // The color travels with each pixel so that a new job cannot change a waiting item.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (emit) begin
      px_q    <= job_q.xs.start + {9'd0, ix_q};
      py_q    <= job_q.ys.start + {9'd0, iy_q};
      cov_q   <= cov;
      last_q  <= last_x && last_y;
      red_q   <= job_q.red;
      green_q <= job_q.green;
      blue_q  <= job_q.blue;
      alpha_q <= job_q.alpha;
    end
  end

  assign out_valid_o = ov_q;
  assign pixel_x_o   = px_q;
  assign pixel_y_o   = py_q;
  assign coverage_o  = cov_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign alpha_o     = alpha_q;
  assign last_o      = last_q;

  // The walk ends only on the final pixel of a job.
  a_end_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> $past(emit && last_x && last_y))
    else $error("back end left a job before its last pixel");

  // Coverage never exceeds a full pixel.
  a_cov_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (cov_q <= ONE_PX))
    else $error("coverage above full");

  // A job taken from the queue always has pixels on both axes.
  a_job_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> ((job_i.xs.count != 4'd0) && (job_i.ys.count != 4'd0)))
    else $error("empty job reached the back end");

endmodule

### design/antialiased_box_splat.sv
// Antialiased box splat. Each particle passes through the front end (side scaling
// by alpha, a reciprocal multiply, edge classification of both axes), which takes no new
// particle until it has queued or dropped the last one; the back end emits its pixels one
// per cycle while the output is not stalled, and its single pixel multiplier bounds the
// sustained rate. QUEUE_DEPTH particles may wait between the two halves.
// Holds the configuration registers and connects abs_front, abs_fifo and abs_back.
module antialiased_box_splat
  import abs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Fields from bit 0: center_x[21:0], center_y[43:22], red[51:44], green[59:52],
  // blue[67:60], alpha[75:68], zero fill[79:76].
  input  logic [79:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: pixel_x[11:0], pixel_y[23:12], coverage[32:24], out_red[40:33],
  // out_green[48:41], out_blue[56:49], out_alpha[64:57], zero fill[71:65].
  output logic [71:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  abs_cfg_t cfg_q;
  logic     cfg_we;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.canvas_width  <= 13'd640;
      cfg_q.canvas_height <= 13'd480;
      cfg_q.box_side      <= 11'd256;
      cfg_q.side_by_alpha <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_CANVAS_WIDTH:  cfg_q.canvas_width  <= pwdata[12:0];
        REG_CANVAS_HEIGHT: cfg_q.canvas_height <= pwdata[12:0];
        REG_BOX_SIDE:      cfg_q.box_side      <= pwdata[10:0];
        REG_SIDE_BY_ALPHA: cfg_q.side_by_alpha <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CANVAS_WIDTH:  prdata = {19'd0, cfg_q.canvas_width};
      REG_CANVAS_HEIGHT: prdata = {19'd0, cfg_q.canvas_height};
      REG_BOX_SIDE:      prdata = {21'd0, cfg_q.box_side};
      REG_SIDE_BY_ALPHA: prdata = {31'd0, cfg_q.side_by_alpha};
      default:           prdata = '0;
    endcase
  end

  abs_job_t push_job, head_job;
  logic     push, full, pop, head_valid;

  abs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .center_x_i (s_axis_tdata[21:0]),
    .center_y_i (s_axis_tdata[43:22]),
    .red_i      (s_axis_tdata[51:44]),
    .green_i    (s_axis_tdata[59:52]),
    .blue_i     (s_axis_tdata[67:60]),
    .alpha_i    (s_axis_tdata[75:68]),
    .push_o     (push),
    .full_i     (full),
    .job_o      (push_job)
  );

  abs_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .rdata_o (head_job)
  );

  logic [11:0] px, py;
  logic [8:0]  cov;
  logic [7:0]  o_r, o_g, o_b, o_a;

  abs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (head_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .pixel_x_o   (px),
    .pixel_y_o   (py),
    .coverage_o  (cov),
    .red_o       (o_r),
    .green_o     (o_g),
    .blue_o      (o_b),
    .alpha_o     (o_a),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, o_a, o_b, o_g, o_r, cov, py, px};

endmodule
